### src/dtlq_pkg.sv
// Shared types and constants for the drop-tail link queue.
package dtlq_pkg;

  localparam int TIME_W  = 48;
  localparam int SIZE_W  = 16;
  localparam int TPB_W   = 16;
  localparam int LIMIT_W = 8;
  localparam int PROD_W  = SIZE_W + TPB_W;
  localparam int DELAY_W = 64;
  localparam int TALLY_W = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_QUEUE_LIMIT    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_BYTE = 1'd1;

  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RESET    = 8'd100;
  localparam logic [TPB_W-1:0]   TICKS_PER_BYTE_RESET = 16'd1600;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic              load;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] base;
  } svc_req_t;

endpackage

### src/dtlq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtlq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/dtlq_svc.sv
// Shared service-time unit: registered size * ticks_per_byte, then saturating add to a base time.
module dtlq_svc import dtlq_pkg::*; (
  input  logic              clk,
  input  svc_req_t          req,
  input  logic [TPB_W-1:0]  ticks_per_byte,
  output logic [TIME_W-1:0] busy_sum
);

  logic [PROD_W-1:0] prod;
  logic [TIME_W-1:0] base;
  logic [TIME_W:0]   sum;

  always_ff @(posedge clk) begin
    if (req.load) begin
      prod <= PROD_W'(req.size) * PROD_W'(ticks_per_byte);
      base <= req.base;
    end
  end

  assign sum      = {1'b0, base} + (TIME_W + 1)'(prod);
  assign busy_sum = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

endmodule

### src/drop_tail_link_queue_unit.sv
// Drop-tail output queue in front of a rate-limited link: sequencer, counters and FIFO control.
// Per arrival, each waiting packet that starts before it passes read, compare, multiply and add
//   steps before the arrival is dropped, served at once or queued.
// Throughput: one arrival at a time; in_ready rises together with out_valid when the result is registered.
// Reset (synchronous, active high) clears link time, FIFO pointers, all counters and the output
// valid, and restores queue_limit to 100 and ticks_per_byte to 1600. FIFO contents are not cleared.
module drop_tail_link_queue_unit import dtlq_pkg::*; #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [TIME_W-1:0]      arrival_tick,
  input  logic [SIZE_W-1:0]      packet_size,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   dropped,
  output logic [7:0]             waiting_count,
  output logic [DELAY_W-1:0]     delay_total,
  output logic [TALLY_W-1:0]     lost_packets,
  output logic [TIME_W-1:0]      lost_bytes,
  output logic [TALLY_W-1:0]     arrival_count
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int RAM_W = TIME_W + SIZE_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CMP    = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_ADD    = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]         state;
  logic [LIMIT_W-1:0] queue_limit;
  logic [TPB_W-1:0]   ticks_per_byte;
  logic [TIME_W-1:0]  busy_until;
  logic [IW-1:0]      head_index;
  logic [IW-1:0]      tail_index;
  logic [CW-1:0]      held_count;
  logic [DELAY_W-1:0] delay_sum;
  logic [TALLY_W-1:0] drop_tally;
  logic [TIME_W-1:0]  drop_bytes;
  logic [TALLY_W-1:0] arrival_tally;
  logic [TIME_W-1:0]  t_r;
  logic [SIZE_W-1:0]  size_r;
  logic [TIME_W-1:0]  start_r;
  logic [TIME_W-1:0]  arr_r;
  logic               serve_r;
  logic               drop_r;

  logic [RAM_W-1:0]   rdata;
  logic               ram_we;
  logic [TIME_W-1:0]  rd_arr;
  logic [SIZE_W-1:0]  rd_size;
  svc_req_t           svc_req;
  logic [TIME_W-1:0]  busy_sum;
  logic [LW-1:0]      count_ext;
  logic [LW-1:0]      limit_eff;
  logic               full;
  logic [TIME_W-1:0]  delay_inc;
  logic [DELAY_W:0]   delay_add;
  logic [TIME_W:0]    bytes_add;
  logic [IW-1:0]      head_next;
  logic [IW-1:0]      tail_next;

  assign rd_arr  = rdata[RAM_W-1:SIZE_W];
  assign rd_size = rdata[SIZE_W-1:0];

  assign count_ext = LW'(held_count);
  assign limit_eff = (LW'(queue_limit) < LW'(QUEUE_DEPTH)) ? LW'(queue_limit) : LW'(QUEUE_DEPTH);
  assign full      = count_ext >= limit_eff;

  assign delay_inc = start_r - arr_r;
  assign delay_add = {1'b0, delay_sum} + (DELAY_W + 1)'(delay_inc);
  assign bytes_add = {1'b0, drop_bytes} + (TIME_W + 1)'(size_r);

  assign head_next = (head_index == IW'(QUEUE_DEPTH - 1)) ? '0 : head_index + 1'b1;
  assign tail_next = (tail_index == IW'(QUEUE_DEPTH - 1)) ? '0 : tail_index + 1'b1;

  assign ram_we = (state == S_DECIDE) && !full && !((held_count == '0) && (busy_until <= t_r));

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    svc_req = '{load: 1'b0, size: rd_size, base: start_r};
    if (state == S_START) begin
      svc_req.load = (start_r < t_r);
    end else if (state == S_DECIDE) begin
      svc_req = '{load: 1'b1, size: size_r, base: t_r};
    end
  end

  dtlq_ram #(
    .WIDTH(RAM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail_index),
    .wdata({t_r, size_r}),
    .raddr(head_index),
    .rdata(rdata)
  );

  dtlq_svc u_svc (
    .clk           (clk),
    .req           (svc_req),
    .ticks_per_byte(ticks_per_byte),
    .busy_sum      (busy_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      queue_limit    <= QUEUE_LIMIT_RESET;
      ticks_per_byte <= TICKS_PER_BYTE_RESET;
      busy_until     <= '0;
      head_index     <= '0;
      tail_index     <= '0;
      held_count     <= '0;
      delay_sum      <= '0;
      drop_tally     <= '0;
      drop_bytes     <= '0;
      arrival_tally  <= '0;
      serve_r        <= 1'b0;
      drop_r         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_QUEUE_LIMIT:    queue_limit <= cfg_data[LIMIT_W-1:0];
          REG_TICKS_PER_BYTE: ticks_per_byte <= cfg_data[TPB_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            t_r     <= arrival_tick;
            size_r  <= packet_size;
            serve_r <= 1'b0;
            drop_r  <= 1'b0;
            if (arrival_tally != '1) begin
              arrival_tally <= arrival_tally + 1'b1;
            end
            state <= (held_count != '0) ? S_CMP : S_DECIDE;
          end
        end
        S_CMP: begin
          arr_r   <= rd_arr;
          start_r <= (busy_until > rd_arr) ? busy_until : rd_arr;
          state   <= S_START;
        end
        S_START: begin
          if (start_r >= t_r) begin
            state <= S_DECIDE;
          end else begin
            delay_sum <= delay_add[DELAY_W] ? '1 : delay_add[DELAY_W-1:0];
            state     <= S_ADD;
          end
        end
        S_ADD: begin
          busy_until <= busy_sum;
          if (serve_r) begin
            state <= S_DONE;
          end else begin
            head_index <= head_next;
            held_count <= held_count - 1'b1;
            state      <= (held_count == CW'(1)) ? S_DECIDE : S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_CMP;
        end
        S_DECIDE: begin
          if (full) begin
            drop_r <= 1'b1;
            if (drop_tally != '1) begin
              drop_tally <= drop_tally + 1'b1;
            end
            drop_bytes <= bytes_add[TIME_W] ? TIME_MAX : bytes_add[TIME_W-1:0];
            state      <= S_DONE;
          end else if ((held_count == '0) && (busy_until <= t_r)) begin
            serve_r <= 1'b1;
            state   <= S_ADD;
          end else begin
            tail_index <= tail_next;
            held_count <= held_count + 1'b1;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || out_ready)) begin
      dropped       <= drop_r;
      waiting_count <= count_ext[7:0];
      delay_total   <= delay_sum;
      lost_packets  <= drop_tally;
      lost_bytes    <= drop_bytes;
      arrival_count <= arrival_tally;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(QUEUE_DEPTH) >= held_count)
    else $error("held_count exceeds queue depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (held_count == '0) |-> (head_index == tail_index))
    else $error("empty queue with unequal pointers");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accepting a transaction");
`endif

endmodule

### test/drop_tail_link_queue_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for drop_tail_link_queue_unit: directed table, random traffic, predictor.
module drop_tail_link_queue_unit_test import dtlq_pkg::*; ();

  localparam int QUEUE_DEPTH = 128;
  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [63:0] TALLY_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic               dropped;
    logic [7:0]         waiting;
    logic [DELAY_W-1:0] delay;
    logic [TALLY_W-1:0] lost_n;
    logic [TIME_W-1:0]  lost_b;
    logic [TALLY_W-1:0] arrivals;
  } link_report_t;

  typedef enum logic [1:0] {ROW_ARRIVAL, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    logic [TIME_W-1:0]      at;
    logic [SIZE_W-1:0]      len;
    logic                   known;
    link_report_t           report;
  } plan_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [TIME_W-1:0]      arrival_tick;
  logic [SIZE_W-1:0]      packet_size;
  logic                   out_valid;
  logic                   out_ready;
  logic                   dropped;
  logic [7:0]             waiting_count;
  logic [DELAY_W-1:0]     delay_total;
  logic [TALLY_W-1:0]     lost_packets;
  logic [TIME_W-1:0]      lost_bytes;
  logic [TALLY_W-1:0]     arrival_count;

  drop_tail_link_queue_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .arrival_tick(arrival_tick),
    .packet_size(packet_size),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .dropped(dropped),
    .waiting_count(waiting_count),
    .delay_total(delay_total),
    .lost_packets(lost_packets),
    .lost_bytes(lost_bytes),
    .arrival_count(arrival_count)
  );

  // predictor state
  logic [7:0]        cfg_limit;
  logic [15:0]       cfg_tpb;
  logic [63:0]       link_free_at;
  logic [TIME_W-1:0] held_at [QUEUE_DEPTH];
  logic [SIZE_W-1:0] held_len [QUEUE_DEPTH];
  int                head_slot;
  int                tail_slot;
  int                held_n;
  logic [63:0]       delay_acc;
  logic [63:0]       lost_n;
  logic [63:0]       lost_b;
  logic [63:0]       arrivals_n;

  link_report_t awaited_reports [$];
  plan_row_t    stimulus_plan [$];
  int           arrivals_sent;
  int           mismatches;
  int           burst_left;
  int           cycle_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [63:0] add_capped(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] cap);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, cap}) ? cap : s[63:0];
  endfunction

  function automatic plan_row_t arrival_row(input logic [TIME_W-1:0] at,
                                            input logic [SIZE_W-1:0] len);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ARRIVAL;
    r.at = at;
    r.len = len;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [TIME_W-1:0] at,
                                          input logic [SIZE_W-1:0] len, input logic drop,
                                          input logic [7:0] waiting, input logic [63:0] delay,
                                          input logic [31:0] lost_count,
                                          input logic [47:0] lost_sum,
                                          input logic [31:0] arrivals);
    plan_row_t r;
    r = arrival_row(at, len);
    r.known = 1'b1;
    r.report.dropped = drop;
    r.report.waiting = waiting;
    r.report.delay = delay;
    r.report.lost_n = lost_count;
    r.report.lost_b = lost_sum;
    r.report.arrivals = arrivals;
    return r;
  endfunction

  function automatic plan_row_t config_row(input logic [CFG_INDEX_W-1:0] index,
                                           input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CONFIG;
    r.index = index;
    r.data = data;
    return r;
  endfunction

  // Starts queued packets that begin before this arrival, then drops, serves or queues it.
  task automatic account_arrival(input logic [TIME_W-1:0] at, input logic [SIZE_W-1:0] len,
                                 input logic known, input link_report_t known_report);
    int           cap;
    logic [63:0]  first_at;
    logic [63:0]  start;
    link_report_t r;
    cap = (cfg_limit < QUEUE_DEPTH) ? int'(cfg_limit) : QUEUE_DEPTH;
    arrivals_n = add_capped(arrivals_n, 64'd1, TALLY_MAX);
    r.dropped = 1'b0;
    while (held_n > 0) begin
      first_at = 64'(held_at[head_slot]);
      start = (link_free_at > first_at) ? link_free_at : first_at;
      if (start >= 64'(at)) break;
      delay_acc = add_capped(delay_acc, start - first_at, '1);
      link_free_at = add_capped(start, 64'(held_len[head_slot]) * 64'(cfg_tpb), 64'(TIME_MAX));
      head_slot = (head_slot == QUEUE_DEPTH - 1) ? 0 : head_slot + 1;
      held_n--;
    end
    if (held_n >= cap) begin
      r.dropped = 1'b1;
      lost_n = add_capped(lost_n, 64'd1, TALLY_MAX);
      lost_b = add_capped(lost_b, 64'(len), 64'(TIME_MAX));
    end else if (held_n == 0 && link_free_at <= 64'(at)) begin
      link_free_at = add_capped(64'(at), 64'(len) * 64'(cfg_tpb), 64'(TIME_MAX));
    end else begin
      held_at[tail_slot] = at;
      held_len[tail_slot] = len;
      tail_slot = (tail_slot == QUEUE_DEPTH - 1) ? 0 : tail_slot + 1;
      held_n++;
    end
    r.waiting = 8'(held_n);
    r.delay = delay_acc;
    r.lost_n = lost_n[TALLY_W-1:0];
    r.lost_b = lost_b[TIME_W-1:0];
    r.arrivals = arrivals_n[TALLY_W-1:0];
    arrivals_sent++;
    awaited_reports.push_back(known ? known_report : r);
  endtask

  task automatic offer_arrival(input logic [TIME_W-1:0] at, input logic [SIZE_W-1:0] len,
                               input logic known, input link_report_t known_report);
    @(negedge clk);
    in_valid <= 1'b1;
    arrival_tick <= at;
    packet_size <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    account_arrival(at, len, known, known_report);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // Registers change only with nothing in flight.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk) in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == REG_QUEUE_LIMIT) cfg_limit = data[7:0];
    else cfg_tpb = data;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic walk_plan(input int first, input int last);
    plan_row_t row;
    for (int i = first; i < last; i++) begin
      row = stimulus_plan[i];
      if (row.kind == ROW_CONFIG) begin
        write_register(row.index, row.data);
      end else begin
        offer_arrival(row.at, row.len, row.known, row.report);
        pace_sender();
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    link_report_t got;
    link_report_t want;
    if (!rst && out_valid && out_ready) begin
      got.dropped = dropped;
      got.waiting = waiting_count;
      got.delay = delay_total;
      got.lost_n = lost_packets;
      got.lost_b = lost_bytes;
      got.arrivals = arrival_count;
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result transaction: drop=%0d wait=%0d delay=%0d", got.dropped,
                   got.waiting, got.delay);
      end else begin
        want = awaited_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch exp: drop=%0d wait=%0d delay=%0d lost=%0d/%0d arrivals=%0d",
                     want.dropped, want.waiting, want.delay, want.lost_n, want.lost_b,
                     want.arrivals);
            $display("         got: drop=%0d wait=%0d delay=%0d lost=%0d/%0d arrivals=%0d",
                     got.dropped, got.waiting, got.delay, got.lost_n, got.lost_b,
                     got.arrivals);
          end
        end
      end
    end
  end

  // receiver: one long hold-off to back the block up, otherwise shifting stall modes
  initial begin
    int          hold_left;
    bit          hold_done;
    int          mode;
    int          mode_left;
    logic [15:0] stall_pattern;
    hold_left = 0;
    hold_done = 1'b0;
    mode = 0;
    mode_left = 0;
    stall_pattern = 16'b1011_0011_1000_1101;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && arrivals_sent >= 150) begin
        hold_done = 1'b1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: begin
            out_ready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
          end
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("drop_tail_link_queue_unit regression: fail");
    $finish;
  end

  initial begin
    int          tail_first;
    int          items;
    int          pick;
    int          twist;
    logic [63:0] t_now;
    logic [63:0] svc;
    logic [63:0] step;
    logic [63:0] at;
    logic [15:0] len;
    logic [7:0]  lim;
    logic [15:0] tpb;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    arrival_tick = '0;
    packet_size = '0;
    mismatches = 0;
    arrivals_sent = 0;
    burst_left = 0;

    cfg_limit = QUEUE_LIMIT_RESET;
    cfg_tpb = TICKS_PER_BYTE_RESET;
    link_free_at = '0;
    head_slot = 0;
    tail_slot = 0;
    held_n = 0;
    delay_acc = '0;
    lost_n = '0;
    lost_b = '0;
    arrivals_n = '0;

    // defaults: idle serve, queue behind busy link, service ending exactly at arrival
    stimulus_plan.push_back(known_row(48'd0, 16'd1, 1'b0, 8'd0, 64'd0, 32'd0, 48'd0, 32'd1));
    stimulus_plan.push_back(known_row(48'd0, 16'hFFFF, 1'b0, 8'd1, 64'd0, 32'd0, 48'd0, 32'd2));
    stimulus_plan.push_back(known_row(48'd1600, 16'd1, 1'b0, 8'd2, 64'd0, 32'd0, 48'd0, 32'd3));
    stimulus_plan.push_back(arrival_row(48'd1601, 16'd100));
    // zero limit drops everything, idle link too
    stimulus_plan.push_back(config_row(REG_QUEUE_LIMIT, 16'h0000));
    stimulus_plan.push_back(arrival_row(48'd1700, 16'd10));
    stimulus_plan.push_back(arrival_row(48'h5555_5555_5555, 16'hFFFF));
    // zero-time service, then a one-deep queue at the slowest rate
    stimulus_plan.push_back(config_row(REG_QUEUE_LIMIT, 16'hA501));
    stimulus_plan.push_back(config_row(REG_TICKS_PER_BYTE, 16'h0000));
    stimulus_plan.push_back(arrival_row(48'h5555_5555_5555, 16'd7));
    stimulus_plan.push_back(arrival_row(48'h5555_5555_5555, 16'd9));
    stimulus_plan.push_back(config_row(REG_TICKS_PER_BYTE, 16'hFFFF));
    stimulus_plan.push_back(arrival_row(48'hAAAA_AAAA_AAAA, 16'hFFFF));
    stimulus_plan.push_back(arrival_row(48'hAAAA_AAAA_AAAA, 16'd1));
    stimulus_plan.push_back(arrival_row(48'hAAAA_AAAA_AAAA, 16'd2));
    // limit above depth, time going backwards
    stimulus_plan.push_back(config_row(REG_QUEUE_LIMIT, 16'h00FF));
    stimulus_plan.push_back(arrival_row(48'h5555_5555_5556, 16'd3));
    stimulus_plan.push_back(arrival_row(48'hAAAA_AAAA_AAAB, 16'h5A5A));
    tail_first = stimulus_plan.size();
    // link time saturates at the top of the range
    stimulus_plan.push_back(config_row(REG_TICKS_PER_BYTE, 16'hFFFF));
    stimulus_plan.push_back(config_row(REG_QUEUE_LIMIT, 16'h0004));
    stimulus_plan.push_back(arrival_row(TIME_MAX - 48'd100, 16'hFFFF));
    stimulus_plan.push_back(arrival_row(TIME_MAX, 16'hFFFF));
    stimulus_plan.push_back(arrival_row(TIME_MAX - 48'd1, 16'd5));
    stimulus_plan.push_back(arrival_row(TIME_MAX, 16'd6));
    stimulus_plan.push_back(arrival_row(TIME_MAX, 16'd1));

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    walk_plan(0, tail_first);

    t_now = 64'h0000_AAAA_AAAA_AAAB;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin lim = 8'($urandom_range(3, 12)); tpb = 16'($urandom_range(1, 100));
          items = 60; end
        1: begin lim = 8'd128; tpb = 16'hFFFF; items = 170; end
        2: begin lim = 8'd1; tpb = 16'd1; items = 50; end
        3: begin lim = 8'hFF; tpb = 16'($urandom_range(1, 65535)); items = 60; end
        4: begin lim = 8'($urandom_range(1, 128)); tpb = 16'($urandom_range(100, 3000));
          items = 60; end
        default: begin lim = QUEUE_LIMIT_RESET; tpb = TICKS_PER_BYTE_RESET; items = 50; end
      endcase
      write_register(REG_QUEUE_LIMIT, {8'($urandom), lim});
      write_register(REG_TICKS_PER_BYTE, tpb);
      for (int k = 0; k < items; k++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) len = 16'd1;
        else if (pick == 1) len = 16'hFFFF;
        else if (pick < 4) len = 16'($urandom_range(1, 65535));
        else len = 16'($urandom_range(40, 1500));
        svc = 64'(len) * 64'(cfg_tpb);
        pick = $urandom_range(0, 99);
        if (p == 1 && pick < 90) step = 0;
        else if (pick < 25) step = 0;
        else if (pick < 55) step = 64'($urandom_range(0, svc[31:0]));
        else if (pick < 85) step = svc / 2 + 64'($urandom_range(0, svc[31:0]));
        else step = svc * 64'($urandom_range(2, 20));
        t_now = t_now + step;
        at = t_now;
        twist = $urandom_range(0, 49);
        if (twist < 3 && link_free_at > t_now) begin
          t_now = link_free_at;
          at = t_now;
        end else if (twist == 3) begin
          at = t_now - 64'($urandom_range(0, 5000));
        end
        offer_arrival(at[TIME_W-1:0], len, 1'b0, '0);
        pace_sender();
      end
    end

    walk_plan(tail_first, stimulus_plan.size());

    @(negedge clk) in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("drop_tail_link_queue_unit regression: pass");
    end else begin
      $display("drop_tail_link_queue_unit regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
src/dtlq_pkg.sv
src/dtlq_ram.sv
src/dtlq_svc.sv
src/drop_tail_link_queue_unit.sv
test/drop_tail_link_queue_unit_test.sv
